// ===== hdl/ssaf_pkg.sv =====
// Package with the shared constants, types and byte fold function of the substring search.
`timescale 1ns / 1ps
package ssaf_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int POS_W = 16;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] UPPER_LO = 8'd65;
  localparam logic [7:0] UPPER_HI = 8'd90;
  localparam logic [7:0] LATIN_LO = 8'd192;
  localparam logic [7:0] LATIN_MID = 8'd214;
  localparam logic [7:0] LATIN_RE = 8'd216;
  localparam logic [7:0] LATIN_HI = 8'd222;
  localparam logic [7:0] CASE_STEP = 8'd32;
  localparam logic [7:0] OE_UPPER = 8'd140;
  localparam logic [7:0] OE_LOWER = 8'd156;
  localparam logic [7:0] S_UPPER = 8'd138;
  localparam logic [7:0] S_LOWER = 8'd154;
  localparam logic [7:0] Y_UPPER = 8'd159;
  localparam logic [7:0] Y_LOWER = 8'd255;

  typedef struct packed {
    logic step;
    logic clear_text;
    logic clear_pat;
  } cell_ctl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= UPPER_LO && c <= UPPER_HI) || (c >= LATIN_LO && c <= LATIN_MID) ||
        (c >= LATIN_RE && c <= LATIN_HI)) begin
      r = c + CASE_STEP;
    end else if (c == OE_UPPER) begin
      r = OE_LOWER;
    end else if (c == S_UPPER) begin
      r = S_LOWER;
    end else if (c == Y_UPPER) begin
      r = Y_LOWER;
    end
    return r;
  endfunction

endpackage

// ===== hdl/ssaf_in_if.sv =====
// Interface of the input channel that carries pattern and text bytes.
`timescale 1ns / 1ps
interface ssaf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output op, output ch, output last, input ready);
  modport sink (input valid, input op, input ch, input last, output ready);
endinterface

// ===== hdl/ssaf_out_if.sv =====
// Interface of the result channel that carries search results.
`timescale 1ns / 1ps
interface ssaf_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] position;
  logic        pattern_too_long;

  modport source (output valid, output found, output position, output pattern_too_long,
                  input ready);
  modport sink (input valid, input found, input position, input pattern_too_long,
                output ready);
endinterface

// ===== hdl/ssaf_cell.sv =====
// One cell of the match chain: holds one pattern byte and one bit of the match vector.
`timescale 1ns / 1ps
module ssaf_cell
  import ssaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic       append_here,
  input  logic [7:0] append_byte,
  input  logic [7:0] text_byte,
  input  logic       case_sensitive,
  input  logic       match_in,
  output logic       match_out,
  output logic       match_nxt
);

  logic [7:0] byte_r;
  logic       active_r;
  logic       match_r;
  logic [7:0] pat_byte;

  assign pat_byte  = case_sensitive ? byte_r : fold_byte(byte_r);
  assign match_nxt = match_in && active_r && (pat_byte == text_byte);
  assign match_out = match_r;

  always_ff @(posedge clk) begin
    if (append_here) begin
      byte_r <= append_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      if (ctl.clear_pat) begin
        active_r <= 1'b0;
      end else if (append_here) begin
        active_r <= 1'b1;
      end
      if (ctl.clear_text) begin
        match_r <= 1'b0;
      end else if (ctl.step) begin
        match_r <= match_nxt;
      end
    end
  end

endmodule

// ===== hdl/substring_search_ansi_fold_core.sv =====
// Top level of the substring search: command decode, cell chain, hit tracking and result register.
//
//   channel  direction  transaction
//   in_chan  sink       op, ch, last: append, text byte or clear pattern
//   out_chan source     found, position, pattern_too_long after a last text byte
//   cfg      write      cfg_we, cfg_wdata: case_sensitive
//
// A transaction is accepted whenever in_chan is ready; all cells compare the text byte in parallel.
// A result is registered at the edge that accepts the last text byte and is valid the next cycle.
// The input is stalled only while a result waits and out_chan is not ready.
// Reset is synchronous and active low; it clears the pattern, text state and result.
`timescale 1ns / 1ps
module substring_search_ansi_fold_core
  import ssaf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  ssaf_in_if.sink      in_chan,
  ssaf_out_if.source   out_chan,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  logic             case_sensitive_r;
  logic [LEN_W-1:0] len_r;
  logic             overflow_r;
  logic [POS_W-1:0] text_count_r;
  logic             hit_seen_r;
  logic [POS_W-1:0] hit_offset_r;
  logic             out_valid_r;
  logic             out_found_r;
  logic [POS_W-1:0] out_position_r;
  logic             out_too_long_r;

  logic             accept;
  logic             do_append;
  logic             do_text;
  logic             do_clear;
  logic             len_full;
  cell_ctl_t        ctl;
  logic [7:0]       text_byte;
  logic [PATTERN_MAX-1:0] chain;
  logic [PATTERN_MAX-1:0] match_nxt;
  logic [PATTERN_MAX-1:0] hit_vec;
  logic             known;
  logic             hit_now;
  logic             new_hit;
  logic [POS_W-1:0] new_offset;
  logic             found_nxt;
  logic [POS_W-1:0] position_nxt;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    do_append = 1'b0;
    do_text   = 1'b0;
    do_clear  = 1'b0;
    unique case (in_chan.op)
      OP_APPEND: do_append = accept;
      OP_TEXT:   do_text   = accept;
      OP_CLEAR:  do_clear  = accept;
      default:   ;
    endcase
  end

  assign len_full       = (len_r == LEN_W'(PATTERN_MAX));
  assign ctl.step       = do_text;
  assign ctl.clear_text = do_append || do_clear || (do_text && in_chan.last);
  assign ctl.clear_pat  = do_clear;
  assign text_byte      = case_sensitive_r ? in_chan.ch : fold_byte(in_chan.ch);

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic link_in;
    if (j == 0) begin : g_head
      assign link_in = 1'b1;
    end else begin : g_body
      assign link_in = chain[j-1];
    end
    ssaf_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .append_here    (do_append && (len_r == LEN_W'(j))),
      .append_byte    (in_chan.ch),
      .text_byte      (text_byte),
      .case_sensitive (case_sensitive_r),
      .match_in       (link_in),
      .match_out      (chain[j]),
      .match_nxt      (match_nxt[j])
    );
    assign hit_vec[j] = match_nxt[j] && (len_r == LEN_W'(j + 1));
  end

  assign known      = (text_count_r != POS_MAX);
  assign hit_now    = (len_r == '0) || (|hit_vec);
  assign new_hit    = !hit_seen_r && known && hit_now;
  assign new_offset = text_count_r + POS_W'(1) - POS_W'(len_r);
  assign found_nxt  = hit_seen_r || new_hit;
  assign position_nxt = hit_seen_r ? hit_offset_r : (new_hit ? new_offset : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sensitive_r <= 1'b1;
      len_r            <= '0;
      overflow_r       <= 1'b0;
      text_count_r     <= '0;
      hit_seen_r       <= 1'b0;
      hit_offset_r     <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case_sensitive_r <= cfg_wdata;
      end
      if (do_clear) begin
        len_r      <= '0;
        overflow_r <= 1'b0;
      end else if (do_append) begin
        if (len_full) begin
          overflow_r <= 1'b1;
        end else begin
          len_r <= len_r + LEN_W'(1);
        end
      end
      if (ctl.clear_text) begin
        text_count_r <= '0;
        hit_seen_r   <= 1'b0;
        hit_offset_r <= '0;
      end else if (do_text) begin
        if (known) begin
          text_count_r <= text_count_r + POS_W'(1);
        end
        if (new_hit) begin
          hit_seen_r   <= 1'b1;
          hit_offset_r <= (len_r == '0) ? '0 : new_offset;
        end
      end
      if (do_text && in_chan.last) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_text && in_chan.last) begin
      out_found_r    <= found_nxt;
      out_position_r <= (len_r == '0 && new_hit) ? '0 : position_nxt;
      out_too_long_r <= overflow_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.found            = out_found_r;
  assign out_chan.position         = out_position_r;
  assign out_chan.pattern_too_long = out_too_long_r;

endmodule

// ===== sim/testbench.sv =====
// Testbench for the substring search core with optional case folding: table-driven, random and long-text searches.
`timescale 1ns / 1ps
module testbench;
  import ssaf_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 600;
  localparam int FOLD_N = 26;
  localparam logic [7:0] FOLD_SET [FOLD_N] = '{
    8'h41, 8'h61, 8'h5A, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hC0, 8'hE0, 8'hD6, 8'hF6, 8'hD7,
    8'hF7, 8'hD8, 8'hF8, 8'hDE, 8'hFE, 8'hDF, 8'hBF, 8'h8C, 8'h9C, 8'h8A, 8'h9A, 8'h9F, 8'hFF
  };

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             too_long;
  } result_t;

  typedef struct packed {
    logic       cfg_row;
    logic [1:0] op;
    logic [7:0] ch;
    logic       last;
    logic       typed;
    result_t    want;
  } row_t;

  localparam result_t MISS = '0;
  localparam result_t HIT_AT_0 = '{1'b1, 16'd0, 1'b0};

  // Configuration rows carry the register value in bit 0 of ch.
  localparam row_t SCRIPT [26] = '{
    '{1'b0, OP_TEXT,   8'h61, 1'b1, 1'b1, HIT_AT_0},
    '{1'b0, OP_TEXT,   8'h00, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'hFF, 1'b1, 1'b1, HIT_AT_0},
    '{1'b0, OP_TEXT,   8'h41, 1'b0, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'h41, 1'b1, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'h62, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h78, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h41, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h62, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b0}},
    '{1'b0, OP_TEXT,   8'h61, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h42, 1'b1, 1'b1, MISS},
    '{1'b0, OP_SPARE,  8'hFF, 1'b1, 1'b0, MISS},
    '{1'b0, OP_CLEAR,  8'h00, 1'b1, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'hFF, 1'b0, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'h00, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'hFF, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h00, 1'b1, 1'b1, HIT_AT_0},
    '{1'b1, OP_APPEND, 8'h00, 1'b0, 1'b0, MISS},
    '{1'b0, OP_CLEAR,  8'h7F, 1'b0, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'h8C, 1'b0, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'h5A, 1'b0, 1'b0, MISS},
    '{1'b0, OP_APPEND, 8'hDE, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h9C, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'h7A, 1'b0, 1'b0, MISS},
    '{1'b0, OP_TEXT,   8'hFE, 1'b1, 1'b1, HIT_AT_0},
    '{1'b1, OP_APPEND, 8'h01, 1'b0, 1'b0, MISS}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  ssaf_in_if in_chan ();
  ssaf_out_if out_chan ();

  substring_search_ansi_fold_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [7:0]             pat_mem [PATTERN_MAX];
  int                     pat_len;
  logic                   pat_over;
  logic [PATTERN_MAX-1:0] prefix_hits;
  logic [POS_W-1:0]       text_pos;
  logic                   hit;
  logic [POS_W-1:0]       hit_at;
  logic                   case_exact;

  result_t     pending [$];
  row_t        cur_row;
  bit          idle_on;
  bit          out_taken;
  int unsigned sink_hold;
  int          mismatches;
  int          cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] ansi_lower(input logic [7:0] c, input logic exact);
    if (exact) begin
      return c;
    end
    if (c inside {[UPPER_LO:UPPER_HI], [LATIN_LO:LATIN_MID], [LATIN_RE:LATIN_HI]}) begin
      return c + CASE_STEP;
    end
    case (c)
      OE_UPPER: return OE_LOWER;
      S_UPPER: return S_LOWER;
      Y_UPPER: return Y_LOWER;
      default: return c;
    endcase
  endfunction

  function automatic void restart_text();
    prefix_hits = '0;
    text_pos = '0;
    hit = 1'b0;
    hit_at = '0;
  endfunction

  // Returns 1 when the transaction closes a search, with the result it should produce.
  function automatic bit search_step(input logic [1:0] op, input logic [7:0] ch,
                                     input logic last, output result_t res);
    logic [7:0]             t;
    logic [PATTERN_MAX-1:0] eq;
    res = '0;
    case (op)
      OP_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end else begin
          pat_over = 1'b1;
        end
        restart_text();
        return 1'b0;
      end
      OP_CLEAR: begin
        pat_len = 0;
        pat_over = 1'b0;
        restart_text();
        return 1'b0;
      end
      OP_TEXT: begin
        t = ansi_lower(ch, case_exact);
        for (int j = 0; j < PATTERN_MAX; j++) begin
          eq[j] = (j < pat_len) && (ansi_lower(pat_mem[j], case_exact) == t);
        end
        prefix_hits = ((prefix_hits << 1) | 1) & eq;
        if (!hit && text_pos != POS_MAX) begin
          if (pat_len == 0) begin
            hit = 1'b1;
            hit_at = '0;
          end else if (prefix_hits[pat_len-1]) begin
            hit = 1'b1;
            hit_at = text_pos + 16'd1 - 16'(pat_len);
          end
        end
        if (text_pos != POS_MAX) begin
          text_pos++;
        end
        if (!last) begin
          return 1'b0;
        end
        res.found = hit;
        res.position = hit ? hit_at : '0;
        res.too_long = pat_over;
        restart_text();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t pred;
    result_t head;
    cycle_count++;
    if (!rst_n) begin
      pat_len = 0;
      pat_over = 1'b0;
      case_exact = 1'b1;
      restart_text();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        out_taken = 1'b1;
        if (pending.size() == 0) begin
          $display("%0t: result with nothing expected, actual found %0d position %0d",
                   $time, out_chan.found, out_chan.position);
          mismatches++;
        end else begin
          head = pending.pop_front();
          report("found", head.found, out_chan.found);
          report("position", head.position, out_chan.position);
          report("pattern_too_long", head.too_long, out_chan.pattern_too_long);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (search_step(in_chan.op, in_chan.ch, in_chan.last, pred)) begin
          pending.push_back(cur_row.typed ? cur_row.want : pred);
        end
      end
      if (cfg_we) begin
        case_exact = cfg_wdata;
      end
    end
  end

  always @(negedge clk) begin
    if (out_taken) begin
      sink_hold = idle_on ? $urandom_range(0, 19) : 0;
      out_taken = 1'b0;
    end
    if (sink_hold != 0) begin
      out_chan.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  function automatic row_t mk(input logic [1:0] op, input logic [7:0] ch, input logic last);
    row_t r;
    r = '0;
    r.op = op;
    r.ch = ch;
    r.last = last;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 2) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return FOLD_SET[$urandom_range(0, FOLD_N - 1)];
  endfunction

  task automatic send(input row_t r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_row = r;
    in_chan.valid <= 1'b1;
    in_chan.op <= r.op;
    in_chan.ch <= r.ch;
    in_chan.last <= r.last;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_case(input logic v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int          text_len;
    int          ins;
    logic [7:0]  b;
    logic [7:0]  pat_q [$];
    in_chan.valid = 1'b0;
    in_chan.op = OP_APPEND;
    in_chan.ch = '0;
    in_chan.last = 1'b0;
    out_chan.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b1;
    rst_n = 1'b0;
    idle_on = 1'b1;
    out_taken = 1'b0;
    sink_hold = 0;
    mismatches = 0;
    cycle_count = 0;
    cur_row = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].cfg_row) begin
        set_case(SCRIPT[i].ch[0]);
      end else begin
        send(SCRIPT[i]);
      end
    end

    // Random searches: random text that may hold the pattern planted in it, with some noise mixed in.
    send(mk(OP_CLEAR, 8'($urandom), 1'($urandom)));
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 7) == 0) begin
        set_case(1'($urandom_range(0, 1)));
      end
      if (pat_q.size() == 0 || $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          send(mk(OP_CLEAR, 8'($urandom), 1'($urandom)));
          pat_q.delete();
          sent++;
        end
        case ($urandom_range(0, 9))
          0, 1: n = $urandom_range(32, 36);
          2, 3: n = $urandom_range(6, 31);
          default: n = $urandom_range(0, 5);
        endcase
        repeat (n) begin
          b = pick_byte();
          send(mk(OP_APPEND, b, 1'($urandom)));
          if (pat_q.size() < PATTERN_MAX) begin
            pat_q.push_back(b);
          end
          sent++;
        end
      end
      text_len = $urandom_range(0, 12);
      ins = $urandom_range(0, 2 * text_len + 1);
      for (int i = 0; i <= text_len; i++) begin
        if (i == ins) begin
          foreach (pat_q[k]) begin
            b = pat_q[k];
            if ($urandom_range(0, 1) == 1 && b != 8'hD7 && b != 8'hF7 &&
                (b | 8'h20) inside {[8'h61:8'h7A], [8'hE0:8'hFE]}) begin
              b = b ^ 8'h20;
            end
            send(mk(OP_TEXT, b, 1'b0));
            sent++;
          end
        end
        case ($urandom_range(0, 29))
          0: send(mk(OP_SPARE, 8'($urandom), 1'($urandom)));
          1: begin
            b = pick_byte();
            send(mk(OP_APPEND, b, 1'($urandom)));
            if (pat_q.size() < PATTERN_MAX) begin
              pat_q.push_back(b);
            end
            sent++;
          end
          default: ;
        endcase
        send(mk(OP_TEXT, pick_byte(), 1'(i == text_len)));
        sent++;
      end
    end

    // Long texts: a match ending on the last countable byte, then one past saturation.
    idle_on = 1'b0;
    send(mk(OP_CLEAR, 8'h00, 1'b0));
    send(mk(OP_APPEND, 8'h5A, 1'b0));
    repeat (int'(POS_MAX) - 1) send(mk(OP_TEXT, 8'h78, 1'b0));
    send(mk(OP_TEXT, 8'h5A, 1'b1));
    repeat (int'(POS_MAX)) send(mk(OP_TEXT, 8'h78, 1'b0));
    send(mk(OP_TEXT, 8'h5A, 1'b0));
    send(mk(OP_TEXT, 8'h5A, 1'b1));

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ssaf_pkg.sv
hdl/ssaf_in_if.sv
hdl/ssaf_out_if.sv
hdl/ssaf_cell.sv
hdl/substring_search_ansi_fold_core.sv
sim/testbench.sv
